// File: rtl/cbpd_pkg.sv
// Shared types, constants and the arctangent table for the cylinder power deposit block.
// No dependencies; every RTL file but cbpd_ram imports this package, and so does the testbench.
`timescale 1ns / 1ps
`default_nettype none
package cbpd_pkg;

  localparam int SECTIONS   = 64;
  localparam int SECTORS    = 64;
  localparam int NODE_COUNT = SECTIONS * SECTORS;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SEC_W      = $clog2(SECTIONS);
  localparam int SECT_W     = $clog2(SECTORS);
  localparam int ACC_W      = 48;
  localparam int CRD_W      = 52;

  localparam logic [1:0] STAT_DEP  = 2'd0;
  localparam logic [1:0] STAT_LEN  = 2'd1;
  localparam logic [1:0] STAT_ANG  = 2'd2;
  localparam logic [1:0] STAT_READ = 2'd3;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_X    = 3'd1;
  localparam logic [2:0] MUL_Y    = 3'd2;
  localparam logic [2:0] MUL_P    = 3'd3;
  localparam logic [2:0] MUL_Q    = 3'd4;
  localparam logic [2:0] MUL_E    = 3'd5;
  localparam logic [2:0] MUL_S1   = 3'd6;
  localparam logic [2:0] MUL_S2   = 3'd7;

  typedef struct packed {
    logic signed [31:0] start_z;
    logic [30:0]        cyl_length;
    logic [31:0]        inv_section_pitch;
    logic [15:0]        angle_start;
    logic [15:0]        angle_end;
    logic [23:0]        inv_angle_span;
    logic [15:0]        power_scale;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [2:0]        mul_op;
    logic              hx_load;
    logic              cordic_init;
    logic              cordic_step;
    logic [3:0]        step;
    logic              angle_load;
    logic              sec_load;
    logic              sect_load;
    logic              pow_load;
    logic [1:0]        node;
    logic              acc_rd;
    logic              acc_wr;
    logic              clr_wr;
    logic [NODE_W-1:0] clr_addr;
    logic              res_load;
    logic [1:0]        res_status;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic len_miss;
    logic ang_miss;
    logic has_front;
  } sts_t;

  // atan(2^-i) in binary angle units
  function automatic logic [13:0] cordic_atan(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cbpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cbpd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/cbpd_regs.sv
// APB-style configuration register file for the deposit block.
// Depends on cbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbpd_regs import cbpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  localparam logic [2:0] REG_START_Z = 3'd0;
  localparam logic [2:0] REG_LENGTH  = 3'd1;
  localparam logic [2:0] REG_PITCH   = 3'd2;
  localparam logic [2:0] REG_A_START = 3'd3;
  localparam logic [2:0] REG_A_END   = 3'd4;
  localparam logic [2:0] REG_SPAN    = 3'd5;
  localparam logic [2:0] REG_SCALE   = 3'd6;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_z           <= '0;
      cfg.cyl_length        <= 31'd65536;
      cfg.inv_section_pitch <= 32'd65536;
      cfg.angle_start       <= 16'd0;
      cfg.angle_end         <= 16'd65535;
      cfg.inv_angle_span    <= 24'd64;
      cfg.power_scale       <= 16'd8225;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_Z: cfg.start_z           <= pwdata;
        REG_LENGTH:  cfg.cyl_length        <= pwdata[30:0];
        REG_PITCH:   cfg.inv_section_pitch <= pwdata;
        REG_A_START: cfg.angle_start       <= pwdata[15:0];
        REG_A_END:   cfg.angle_end         <= pwdata[15:0];
        REG_SPAN:    cfg.inv_angle_span    <= pwdata[23:0];
        REG_SCALE:   cfg.power_scale       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_Z: prdata = cfg.start_z;
      REG_LENGTH:  prdata = {1'b0, cfg.cyl_length};
      REG_PITCH:   prdata = cfg.inv_section_pitch;
      REG_A_START: prdata = {16'd0, cfg.angle_start};
      REG_A_END:   prdata = {16'd0, cfg.angle_end};
      REG_SPAN:    prdata = {8'd0, cfg.inv_angle_span};
      REG_SCALE:   prdata = {16'd0, cfg.power_scale};
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cbpd_ctrl.sv
// Sequencer for the deposit block: memory clear, multiply schedule, CORDIC steps,
// node read-modify-write and result handoff. Depends on cbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbpd_ctrl import cbpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MULX  = 4'd2;
  localparam logic [3:0] S_MULY  = 4'd3;
  localparam logic [3:0] S_CINIT = 4'd4;
  localparam logic [3:0] S_CSTEP = 4'd5;
  localparam logic [3:0] S_ANGLE = 4'd6;
  localparam logic [3:0] S_MULP  = 4'd7;
  localparam logic [3:0] S_MULQ  = 4'd8;
  localparam logic [3:0] S_MULE  = 4'd9;
  localparam logic [3:0] S_POW   = 4'd10;
  localparam logic [3:0] S_NS1   = 4'd11;
  localparam logic [3:0] S_NS2   = 4'd12;
  localparam logic [3:0] S_NWR   = 4'd13;
  localparam logic [3:0] S_RD    = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]        state;
  logic [NODE_W-1:0] clr_cnt;
  logic [3:0]        step;
  logic [1:0]        node;
  logic [1:0]        res;
  logic              out_free;
  logic              last_node;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign last_node = (node == 2'd3) || (node == 2'd1 && !sts.has_front);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      step      <= '0;
      node      <= '0;
      res       <= STAT_DEP;
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NODE_W'(NODE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) state <= S_MULX;
        S_MULX: begin
          if (sts.op_read) begin
            state <= S_RD;
          end else if (sts.len_miss) begin
            res   <= STAT_LEN;
            state <= S_FIN;
          end else begin
            state <= S_MULY;
          end
        end
        S_MULY:  state <= S_CINIT;
        S_CINIT: begin
          step  <= '0;
          state <= S_CSTEP;
        end
        S_CSTEP: begin
          step <= step + 1'b1;
          if (step == 4'd15) state <= S_ANGLE;
        end
        S_ANGLE: state <= S_MULP;
        S_MULP: begin
          if (sts.ang_miss) begin
            res   <= STAT_ANG;
            state <= S_FIN;
          end else begin
            state <= S_MULQ;
          end
        end
        S_MULQ: state <= S_MULE;
        S_MULE: state <= S_POW;
        S_POW: begin
          node  <= '0;
          state <= S_NS1;
        end
        S_NS1: state <= S_NS2;
        S_NS2: state <= S_NWR;
        S_NWR: begin
          if (last_node) begin
            res   <= STAT_DEP;
            state <= S_FIN;
          end else begin
            node  <= node + 1'b1;
            state <= S_NS1;
          end
        end
        S_RD: begin
          res   <= STAT_READ;
          state <= S_FIN;
        end
        S_FIN: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    cmd.node       = node;
    cmd.clr_addr   = clr_cnt;
    cmd.res_status = res;
    unique case (state)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_MULX:  cmd.mul_op = MUL_X;
      S_MULY: begin
        cmd.mul_op  = MUL_Y;
        cmd.hx_load = 1'b1;
      end
      S_CINIT: cmd.cordic_init = 1'b1;
      S_CSTEP: cmd.cordic_step = 1'b1;
      S_ANGLE: cmd.angle_load = 1'b1;
      S_MULP:  cmd.mul_op = MUL_P;
      S_MULQ: begin
        cmd.mul_op  = MUL_Q;
        cmd.sec_load = 1'b1;
      end
      S_MULE: begin
        cmd.mul_op    = MUL_E;
        cmd.sect_load = 1'b1;
      end
      S_POW: cmd.pow_load = 1'b1;
      S_NS1: begin
        cmd.mul_op = MUL_S1;
        cmd.acc_rd = 1'b1;
      end
      S_NS2: cmd.mul_op = MUL_S2;
      S_NWR: cmd.acc_wr = 1'b1;
      S_RD:  cmd.acc_rd = 1'b1;
      S_FIN: cmd.res_load = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cbpd_dp.sv
// Datapath: hit point, shared multiplier, CORDIC angle, bilinear weights,
// accumulator memory and result registers. Depends on cbpd_pkg and cbpd_ram.
`timescale 1ns / 1ps
`default_nettype none
module cbpd_dp import cbpd_pkg::*; (
  input  wire logic               clk,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               op,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] slope_x,
  input  wire logic signed [31:0] slope_y,
  input  wire logic [31:0]        energy,
  input  wire logic signed [31:0] path_param,
  input  wire logic [11:0]        node_index,
  output logic [1:0]              status,
  output logic [5:0]              section_index,
  output logic [5:0]              sector_index,
  output logic [47:0]             node_power
);

  logic                     op_rd;
  logic signed [31:0]       px, py, sx, sy, tp;
  logic [31:0]              en;
  logic [11:0]              nidx;
  logic signed [33:0]       lz;
  logic signed [67:0]       prod;
  logic signed [33:0]       mul_a, mul_b;
  logic signed [CRD_W-1:0]  hx, hy, cx, cy, dx, dy;
  logic [15:0]              z;
  logic                     axis;
  logic [15:0]              ang;
  logic [SEC_W-1:0]         sec, sec_sel;
  logic [SECT_W-1:0]        sect, sfront, sect_sel;
  logic [15:0]              fs, fa;
  logic [31:0]              power;
  logic [16:0]              w1, w2;
  logic [NODE_W-1:0]        node_addr, rd_addr, waddr, raddr;
  logic [ACC_W-1:0]         rdata, acc_sat, wdata;
  logic [ACC_W:0]           acc_sum;
  logic [13:0]              atan_v;
  logic                     rd_in_range;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_rd <= op;
      px    <= pos_x;
      py    <= pos_y;
      sx    <= slope_x;
      sy    <= slope_y;
      tp    <= path_param;
      en    <= energy;
      nidx  <= node_index;
      lz    <= {{2{pos_z[31]}}, pos_z} + {{2{path_param[31]}}, path_param}
             - {{2{cfg.start_z[31]}}, cfg.start_z};
    end
  end

  assign sts.op_read   = op_rd;
  assign sts.len_miss  = (lz <= 34'sd0) || (lz > $signed({3'b000, cfg.cyl_length}));
  assign sts.ang_miss  = (ang < cfg.angle_start) || (ang > cfg.angle_end);
  assign sts.has_front = (32'(sec) + 32'd1) < 32'(SECTIONS);

  // shared multiplier, one product per cycle
  always_comb begin
    case (cmd.mul_op)
      MUL_X: begin
        mul_a = {{2{sx[31]}}, sx};
        mul_b = {{2{tp[31]}}, tp};
      end
      MUL_Y: begin
        mul_a = {{2{sy[31]}}, sy};
        mul_b = {{2{tp[31]}}, tp};
      end
      MUL_P: begin
        mul_a = lz;
        mul_b = {2'b00, cfg.inv_section_pitch};
      end
      MUL_Q: begin
        mul_a = {18'd0, ang - cfg.angle_start};
        mul_b = {10'd0, cfg.inv_angle_span};
      end
      MUL_E: begin
        mul_a = {2'b00, en};
        mul_b = {18'd0, cfg.power_scale};
      end
      MUL_S1: begin
        mul_a = {2'b00, power};
        mul_b = {17'd0, w1};
      end
      MUL_S2: begin
        mul_a = prod[49:16];
        mul_b = {17'd0, w2};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  assign hy = {{(CRD_W-32){py[31]}}, py} + prod[67:16];

  always_ff @(posedge clk) begin
    if (cmd.hx_load) begin
      hx <= {{(CRD_W-32){px[31]}}, px} + prod[67:16];
    end
  end

  // vectoring CORDIC on (y, x), one micro-rotation per cycle
  assign dx     = cy >>> cmd.step;
  assign dy     = cx >>> cmd.step;
  assign atan_v = cordic_atan(cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      axis <= (hx == '0) && (hy == '0);
      if (hy[CRD_W-1]) begin
        cx <= -hy;
        cy <= -hx;
        z  <= 16'd0;
      end else begin
        cx <= hy;
        cy <= hx;
        z  <= 16'd32768;
      end
    end else if (cmd.cordic_step) begin
      if (!cy[CRD_W-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        z  <= z + {2'b00, atan_v};
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        z  <= z - {2'b00, atan_v};
      end
    end
    if (cmd.angle_load) begin
      ang <= axis ? 16'd32768 : z;
    end
  end

  // clamp the last section and sector with zero weight
  always_ff @(posedge clk) begin
    if (cmd.sec_load) begin
      if (prod[63:32] >= 32'(SECTIONS - 1)) begin
        sec <= SEC_W'(SECTIONS - 1);
        fs  <= 16'd0;
      end else begin
        sec <= prod[32 +: SEC_W];
        fs  <= prod[31:16];
      end
    end
    if (cmd.sect_load) begin
      if (prod[39:16] >= 24'(SECTORS)) begin
        sect <= SECT_W'(SECTORS - 1);
        fa   <= 16'd0;
      end else begin
        sect <= prod[16 +: SECT_W];
        fa   <= prod[15:0];
      end
    end
    if (cmd.pow_load) begin
      power <= prod[47:16];
    end
  end

  assign sfront   = (sect == SECT_W'(SECTORS - 1)) ? '0 : sect + 1'b1;
  assign sec_sel  = cmd.node[1] ? sec + 1'b1 : sec;
  assign sect_sel = cmd.node[0] ? sfront : sect;
  assign w1       = cmd.node[1] ? {1'b0, fs} : 17'h10000 - {1'b0, fs};
  assign w2       = cmd.node[0] ? {1'b0, fa} : 17'h10000 - {1'b0, fa};
  assign node_addr = NODE_W'(sec_sel) * NODE_W'(SECTORS) + NODE_W'(sect_sel);
  assign rd_addr   = NODE_W'(nidx);
  assign rd_in_range = 32'(nidx) < 32'(NODE_COUNT);

  assign acc_sum = {1'b0, rdata} + (ACC_W + 1)'(prod[48:16]);
  assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  assign waddr   = cmd.clr_wr ? cmd.clr_addr : node_addr;
  assign wdata   = cmd.clr_wr ? '0 : acc_sat;
  assign raddr   = op_rd ? rd_addr : node_addr;

  cbpd_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NODE_COUNT)
  ) u_acc (
    .clk   (clk),
    .we    (cmd.clr_wr || cmd.acc_wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.acc_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status        <= cmd.res_status;
      section_index <= (cmd.res_status == STAT_DEP) ? 6'(sec) : 6'd0;
      sector_index  <= (cmd.res_status == STAT_DEP) ? 6'(sect) : 6'd0;
      node_power    <= (cmd.res_status == STAT_READ && rd_in_range) ? rdata : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cylinder_bilinear_power_deposit.sv
// Cylindrical-wall power deposition with bilinear weighting onto a 64 x 64 node mesh.
// Input channel (in_valid / in_stall) takes a deposit or a read item; output channel
// (out_valid / out_stall) returns one result item per input item.
// Configuration registers sit on an APB-style port, one 32-bit word every 4 bytes.
// After reset the accumulator memory is zeroed by a sweep of all 4096 entries, one entry a
// cycle; in_stall stays high until the sweep ends. Configuration writes go through.
// Paths through the sequencer: a read item goes MULX, RD, FIN; a deposit missing the
// length test goes MULX, FIN; a deposit missing the angle span leaves for FIN at MULP,
// after the CORDIC; a deposit hitting the last section updates two nodes, any other four.
// One item is in flight at a time; the next item can be taken in the cycle after the
// result is loaded. A deposit runs the 16-step CORDIC and the read-modify-write of up to
// four nodes through the accumulator memory, one node after another.
// The result sits in an output register: while out_stall is high the block may accept
// the next item and work on it, and holds at its final step until the register frees.
// Depends on cbpd_pkg, cbpd_regs, cbpd_ctrl, cbpd_dp, cbpd_ram.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_bilinear_power_deposit import cbpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] slope_x,
  input  wire logic signed [31:0] slope_y,
  input  wire logic [31:0]        energy,
  input  wire logic signed [31:0] path_param,
  input  wire logic [11:0]        node_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [5:0]              section_index,
  output logic [5:0]              sector_index,
  output logic [47:0]             node_power
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  cbpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbpd_dp u_dp (
    .clk           (clk),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .slope_x       (slope_x),
    .slope_y       (slope_y),
    .energy        (energy),
    .path_param    (path_param),
    .node_index    (node_index),
    .status        (status),
    .section_index (section_index),
    .sector_index  (sector_index),
    .node_power    (node_power)
  );

  // the memory sweep follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted during accumulator clear");

  a_power_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_READ |-> node_power == 48'd0)
    else $error("node power on a non-read result");

  a_miss_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_LEN || status == STAT_ANG || status == STAT_READ)
    |-> section_index == 6'd0 && sector_index == 6'd0)
    else $error("mesh index on a miss or read result");

endmodule
`default_nettype wire

// File: sim/tb_cylinder_bilinear_power_deposit.sv
// Self-checking testbench for cylinder_bilinear_power_deposit: directed table, then random
// deposit/read items over several register settings, checked against an in-bench predictor.
// Depends on cbpd_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_cylinder_bilinear_power_deposit import cbpd_pkg::*;;

  typedef struct {
    bit               op;
    logic signed [31:0] px, py, pz, sx, sy, t;
    logic [31:0]      energy;
    logic [11:0]      node;
  } item_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  sec;
    logic [5:0]  sect;
    logic [47:0] power;
  } res_t;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  localparam logic [4:0] REG_START_Z = 5'd0,  REG_LENGTH = 5'd4,  REG_INV_PITCH = 5'd8;
  localparam logic [4:0] REG_ANG_START = 5'd12, REG_ANG_END = 5'd16;
  localparam logic [4:0] REG_INV_SPAN = 5'd20, REG_SCALE = 5'd24;
  localparam logic [47:0] ACC_FULL = 48'hFFFF_FFFF_FFFF;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, op;
  logic signed [31:0] pos_x, pos_y, pos_z, slope_x, slope_y, path_param;
  logic [31:0] energy;
  logic [11:0] node_index;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [5:0] section_index, sector_index;
  logic [47:0] node_power;

  cylinder_bilinear_power_deposit uut (.*);

  cfg_t        regs;
  logic [47:0] node_acc [NODE_COUNT];
  res_t        pending [$];
  row_t        rows [$];
  int          mismatches = 0;
  int          stall_left = 0;
  int          gap_max = 12;
  int          stall_max = 12;
  int          atan_tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                 5, 3, 1, 1, 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL cylinder_bilinear_power_deposit");
    $finish;
  end

  function automatic logic [15:0] hit_angle(input longint hx, input longint hy);
    longint cx, cy, z, dx, dy;
    longint off;
    cx = hy;
    cy = hx;
    z = 0;
    off = 32768;
    if (cx == 0 && cy == 0) return 16'd32768;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      off += 32768;
    end
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        z += atan_tab[i];
      end else begin
        cx -= dx;
        cy += dy;
        z -= atan_tab[i];
      end
    end
    return 16'(z + off);
  endfunction

  function automatic logic [47:0] node_share(input longint unsigned p,
                                             input longint unsigned w1,
                                             input longint unsigned w2);
    return 48'((((p * w1) >> 16) * w2) >> 16);
  endfunction

  function automatic void add_power(input longint unsigned idx, input logic [47:0] v);
    logic [48:0] s;
    if (idx >= NODE_COUNT) return;
    s = {1'b0, node_acc[idx]} + {1'b0, v};
    node_acc[idx] = s > {1'b0, ACC_FULL} ? ACC_FULL : s[47:0];
  endfunction

  // Apply one item to the mesh image and return the result the block must give.
  function automatic res_t deposit_result(input item_t it);
    res_t r;
    longint lz, hx, hy;
    longint unsigned p, q, sec, sect, fs, fa, pw, front, row;
    logic [15:0] a;
    r = '{status: STAT_DEP, sec: 6'd0, sect: 6'd0, power: 48'd0};
    if (it.op) begin
      r.status = STAT_READ;
      r.power = it.node < NODE_COUNT ? node_acc[it.node] : 48'd0;
      return r;
    end
    lz = longint'(it.pz) + longint'(it.t) - longint'(regs.start_z);
    if (lz <= 0 || lz > longint'({1'b0, regs.cyl_length})) begin
      r.status = STAT_LEN;
      return r;
    end
    hx = longint'(it.px) + ((longint'(it.sx) * longint'(it.t)) >>> 16);
    hy = longint'(it.py) + ((longint'(it.sy) * longint'(it.t)) >>> 16);
    a = hit_angle(hx, hy);
    if (a < regs.angle_start || a > regs.angle_end) begin
      r.status = STAT_ANG;
      return r;
    end
    p = longint'(lz) * longint'({32'd0, regs.inv_section_pitch});
    sec = p >> 32;
    fs = (p >> 16) & 64'hFFFF;
    if (sec >= SECTIONS - 1) begin
      sec = SECTIONS - 1;
      fs = 0;
    end
    q = longint'({48'd0, a - regs.angle_start}) * longint'({40'd0, regs.inv_angle_span});
    sect = q >> 16;
    fa = q & 64'hFFFF;
    if (sect >= SECTORS) begin
      sect = SECTORS - 1;
      fa = 0;
    end
    front = (sect + 1 >= SECTORS) ? 0 : sect + 1;
    pw = (longint'({32'd0, it.energy}) * longint'({48'd0, regs.power_scale})) >> 16;
    row = sec * SECTORS;
    add_power(row + sect, node_share(pw, 65536 - fs, 65536 - fa));
    add_power(row + front, node_share(pw, 65536 - fs, fa));
    if (sec + 1 < SECTIONS) begin
      add_power(row + SECTORS + sect, node_share(pw, fs, 65536 - fa));
      add_power(row + SECTORS + front, node_share(pw, fs, fa));
    end
    r.sec = 6'(sec);
    r.sect = 6'(sect);
    return r;
  endfunction

  task automatic write_reg(input logic [4:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (addr)
      REG_START_Z:   regs.start_z = data;
      REG_LENGTH:    regs.cyl_length = data[30:0];
      REG_INV_PITCH: regs.inv_section_pitch = data;
      REG_ANG_START: regs.angle_start = data[15:0];
      REG_ANG_END:   regs.angle_end = data[15:0];
      REG_INV_SPAN:  regs.inv_angle_span = data[23:0];
      default:       regs.power_scale = data[15:0];
    endcase
  endtask

  task automatic set_mesh(input logic [31:0] sz, input logic [31:0] len,
                          input logic [31:0] pitch, input logic [15:0] a0,
                          input logic [15:0] a1, input logic [23:0] span,
                          input logic [15:0] scale);
    write_reg(REG_START_Z, sz);
    write_reg(REG_LENGTH, len);
    write_reg(REG_INV_PITCH, pitch);
    write_reg(REG_ANG_START, {16'd0, a0});
    write_reg(REG_ANG_END, {16'd0, a1});
    write_reg(REG_INV_SPAN, {8'd0, span});
    write_reg(REG_SCALE, {16'd0, scale});
  endtask

  // Wait until every result is back, then let the block settle.
  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t r;
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = it.op;
    pos_x = it.px;
    pos_y = it.py;
    pos_z = it.pz;
    slope_x = it.sx;
    slope_y = it.sy;
    energy = it.energy;
    path_param = it.t;
    node_index = it.node;
    do @(posedge clk); while (in_stall);
    r = deposit_result(it);
    if (typed) r = want;
    pending = {pending, r};
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic item_t rand_item(input bit hit);
    item_t it;
    longint lz, pzl;
    it.op = ($urandom_range(0, 4) == 0);
    it.node = $urandom;
    it.energy = $urandom;
    if (!hit) begin
      it.px = $urandom;
      it.py = $urandom;
      it.pz = $urandom;
      it.sx = $urandom;
      it.sy = $urandom;
      it.t = $urandom;
      return it;
    end
    it.px = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    it.py = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    it.sx = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    it.sy = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    it.t = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    lz = $urandom_range(1, regs.cyl_length == 0 ? 1 : regs.cyl_length);
    pzl = longint'(regs.start_z) + lz - longint'(it.t);
    it.pz = 32'(pzl);
    return it;
  endfunction

  function automatic item_t mk(input bit o, input int x, input int y, input int z,
                               input int a, input int b, input int e, input int t,
                               input int n);
    item_t it;
    it = '{op: o, px: x, py: y, pz: z, sx: a, sy: b, energy: e, t: t, node: n};
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit typed, input logic [1:0] st);
    row_t rw;
    rw.it = it;
    rw.typed = typed;
    rw.want = '{status: st, sec: 6'd0, sect: 6'd0, power: 48'd0};
    rows = {rows, rw};
  endtask

  // Result checker.
  always @(posedge clk) begin
    res_t w;
    if (!rst && out_valid && !out_stall) begin
      stall_left = $urandom_range(0, stall_max);
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        w = pending.pop_front();
        if (status !== w.status || section_index !== w.sec || sector_index !== w.sect ||
            node_power !== w.power) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0h got %0d/%0d/%0d/%0h",
                     w.status, w.sec, w.sect, w.power,
                     status, section_index, sector_index, node_power);
        end
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (out_valid && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    res_t none;
    item_t it;
    none = '{status: STAT_DEP, sec: 6'd0, sect: 6'd0, power: 48'd0};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    op = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    slope_x = '0;
    slope_y = '0;
    energy = '0;
    path_param = '0;
    node_index = '0;
    out_stall = 1'b0;
    regs = '{start_z: 0, cyl_length: 65536, inv_section_pitch: 65536, angle_start: 0,
             angle_end: 65535, inv_angle_span: 64, power_scale: 8225};
    foreach (node_acc[i]) node_acc[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: fresh mesh, length misses, axis, negative y axis, wrap, extremes.
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, STAT_READ);
    add_row(mk(1, -1, -1, -1, -1, -1, -1, -1, 4095), 1, STAT_READ);
    add_row(mk(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0), 1, STAT_LEN);
    add_row(mk(0, 0, 0, 32'h7FFFFFFF, 0, 0, 1, 32'h7FFFFFFF, 0), 1, STAT_LEN);
    add_row(mk(0, 0, 0, 32'h80000000, 0, 0, 1, 32'h80000000, 0), 1, STAT_LEN);
    add_row(mk(0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 32'h10001, 0), 1, STAT_LEN);
    add_row(mk(0, 0, 0, 0, 0, 0, 32'h10000, 32'h8000, 0), 0, STAT_DEP);
    add_row(mk(0, 0, -65536, 0, 0, 0, 32'hFFFFFFFF, 32'h8000, 0), 0, STAT_DEP);
    add_row(mk(0, -1, -6553600, 0, 0, 0, 32'hFFFFFFFF, 32'h4000, 0), 0, STAT_DEP);
    add_row(mk(0, 65536, 0, 0, 0, 0, 32'hFFFFFFFF, 32'h10000, 0), 0, STAT_DEP);
    add_row(mk(0, 32'h7FFFFFFF, 32'h80000000, 65535, 32'h80000000, 32'h7FFFFFFF,
               32'h12345678, 1, 0), 0, STAT_DEP);
    add_row(mk(0, -5, 7, 32'h7FFF0000, 32'h7FFFFFFF, 32'h80000000, 1,
               32'h80010000 + 32'h0000C000, 0), 0, STAT_DEP);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 32), 0, STAT_READ);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 96), 0, STAT_READ);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 63), 0, STAT_READ);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 0, STAT_READ);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 64), 0, STAT_READ);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    release_input();
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_mesh(0, 64 << 16, 64512, 0, 65535, 64, 65535);
        1: set_mesh(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16384, 49151, 24'hFFFFFF, 0);
        2: set_mesh(32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, 65535, 0, 1);
        3: set_mesh(-32'sh100000, 32 << 16, 32'h20000, 40000, 100, 64, 8225);
        4: set_mesh(0, 0, 65536, 65535, 65535, 64, 8225);
        5: set_mesh(12345, 8 << 16, 32'h80000, 0, 65535, 64, 40000);
        default: set_mesh($urandom_range(0, 32'h3FFFFF) - 32'h200000,
                          $urandom_range(1, 32'h7FFFFF), $urandom,
                          $urandom_range(0, 32767), $urandom_range(32768, 65535),
                          $urandom_range(0, 255), $urandom);
      endcase
      gap_max = (ph % 3 == 1) ? 0 : 12;
      stall_max = (ph % 4 == 2) ? 0 : 12;
      for (int k = 0; k < 72; k++) begin
        it = rand_item($urandom_range(0, 5) != 0);
        send_item(it, 0, none);
      end
      release_input();
      drain();
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS cylinder_bilinear_power_deposit");
    end else begin
      $display("FAIL cylinder_bilinear_power_deposit");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cbpd_pkg.sv
rtl/cbpd_ram.sv
rtl/cbpd_regs.sv
rtl/cbpd_ctrl.sv
rtl/cbpd_dp.sv
rtl/cylinder_bilinear_power_deposit.sv
sim/tb_cylinder_bilinear_power_deposit.sv
